@@ hw/rtl/pfba_pkg.sv @@
package pfba_pkg;

   // default geometry of the frame map
   localparam int MAP_WORDS_DEF = 256;
   localparam int WORD_BITS_DEF = 64;

   // summary bits are searched in groups of this many words
   localparam int SUM_GROUP = 64;

   // fixed field widths
   localparam int MODE_W      = 2;
   localparam int FRAME_NUM_W = 14;
   localparam int CFG_W       = 15;
   localparam int END_RESET   = 16384;

   // request modes
   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC = 2'd0,
      MODE_FREE  = 2'd1,
      MODE_INIT  = 2'd2,
      MODE_NOP   = 2'd3
   } mode_type;

   // configuration register indexes
   typedef enum logic {
      CSR_FIRST_FREE = 1'b0,
      CSR_END_FRAME  = 1'b1
   } csr_index_type;

   // response status codes
   localparam logic STATUS_DONE  = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   // control sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GROUP,
      ST_WORD,
      ST_ALLOC,
      ST_FREE_DIV,
      ST_FREE_RD,
      ST_FREE_WB,
      ST_INIT,
      ST_RESP
   } state_type;

   // result of a lowest set bit search
   typedef struct packed {
      logic       found;
      logic [5:0] idx;
   } lowest_type;

   // position of the lowest set bit of a 64 bit vector
   function automatic lowest_type lowest_set(input logic [63:0] vec);
      lowest_type r;
      r.found = |vec;
      r.idx   = '0;
      for (int i = 63; i >= 0; i--) begin
         if (vec[i]) begin
            r.idx = 6'(i);
         end
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/pfba_map.sv @@
module pfba_map
   import pfba_pkg::*;
#(
   parameter int  MAP_WORDS = MAP_WORDS_DEF,
   parameter int  WORD_BITS = WORD_BITS_DEF,
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1,
   localparam int GROUPS    = (MAP_WORDS + SUM_GROUP - 1) / SUM_GROUP,
   localparam int SUM_W     = GROUPS * SUM_GROUP
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output logic [WORD_BITS-1:0]  rd_data,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [WORD_BITS-1:0]  wr_data,
   output logic [SUM_W-1:0]      summary,
   output logic [GROUPS-1:0]     group_any
);

   logic [WORD_BITS-1:0] mem [MAP_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_valid_ff;
   logic [SUM_W-1:0]     summary_ff;
   logic [GROUPS-1:0]    group_any_ff;

   // word storage, one read and one write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // nonempty flag per word, doubles as the written flag of the word
   always_ff @(posedge clock) begin
      if (reset) begin
         summary_ff  <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            summary_ff[wr_addr] <= |wr_data;
         end
         if (rd_en) begin
            rd_valid_ff <= summary_ff[rd_addr];
         end
      end
   end

   // per group nonempty flags, registered from the summary
   always_ff @(posedge clock) begin
      if (reset) begin
         group_any_ff <= '0;
      end else begin
         for (int g = 0; g < GROUPS; g++) begin
            group_any_ff[g] <= |summary_ff[g*SUM_GROUP +: SUM_GROUP];
         end
      end
   end

   // a word whose flag is clear holds no free frame
   assign rd_data   = rd_valid_ff ? rd_data_ff : '0;
   assign summary   = summary_ff;
   assign group_any = group_any_ff;

endmodule

@@ hw/rtl/page_frame_bitmap_allocator_top.sv @@
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_stall | req_mode, req_frame_number
// rsp     | out       | rsp_valid / rsp_stall | rsp_granted_frame, rsp_status
// csr     | in        | csr_valid / csr_ready | csr_index, csr_wdata
//
// one transaction at a time; the result appears the cycle after the last step
// allocate: accept, group flag search, word flag search and map read, write back;
//    an empty map goes from the group flag search to the response; free: reciprocal divide, read, write
// initialize: one map word written per cycle, the last once the output is free; no-op: accept, response
// reset clears the per word nonempty flags, so the map reads empty with no clearing pass
// a stalled result is held in the output register while the next request is taken;
//    the next result waits in its last step until the previous one is taken
module page_frame_bitmap_allocator_top
   import pfba_pkg::*;
#(
   parameter int MAP_WORDS = MAP_WORDS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [MODE_W-1:0]      req_mode,
   input  logic [FRAME_NUM_W-1:0] req_frame_number,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [FRAME_NUM_W-1:0] rsp_granted_frame,
   output logic                   rsp_status,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [CFG_W-1:0]       csr_wdata
);

   localparam int AW     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BW     = $clog2(WORD_BITS);
   localparam int GROUPS = (MAP_WORDS + SUM_GROUP - 1) / SUM_GROUP;
   localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int SUM_W  = GROUPS * SUM_GROUP;
   localparam int TOTAL  = MAP_WORDS * WORD_BITS;
   localparam int FW     = $clog2(TOTAL + 1);
   localparam int CW     = ((FW > CFG_W) ? FW : CFG_W) + 1;
   // frame to word index by reciprocal multiply
   localparam int SH     = FRAME_NUM_W + $clog2(WORD_BITS);
   localparam int RECIP  = ((2 ** SH) + WORD_BITS - 1) / WORD_BITS;
   localparam int PW     = SH + FRAME_NUM_W + 1;
   localparam int RW     = FRAME_NUM_W + 1;

   state_type              state_ff, state_in;
   mode_type               req_mode_t;
   logic [FRAME_NUM_W-1:0] frame_ff;
   logic [FRAME_NUM_W-1:0] quot_ff;
   logic [GW-1:0]          grp_ff;
   logic [AW-1:0]          word_ff;
   logic [BW-1:0]          bit_ff;
   logic [CW-1:0]          base_ff;
   logic                   pend_status_ff;
   logic [CFG_W-1:0]       first_ff;
   logic [CFG_W-1:0]       end_ff;
   logic                   rsp_valid_ff;
   logic [FRAME_NUM_W-1:0] rsp_frame_ff;
   logic                   rsp_status_ff;

   logic                   out_free;
   logic                   finish;
   logic [FRAME_NUM_W-1:0] fin_frame;
   logic                   fin_status;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic [WORD_BITS-1:0]   rd_data;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [WORD_BITS-1:0]   wr_data;
   logic [SUM_W-1:0]       summary;
   logic [GROUPS-1:0]      group_any;

   lowest_type             grp_sel;
   lowest_type             word_sel;
   lowest_type             bit_sel;
   logic [GW+5:0]          word_full;
   logic [AW-1:0]          word_pick;
   logic [FW-1:0]          alloc_frame;
   logic [PW-1:0]          div_prod;
   logic [RW-1:0]          quot_wb;
   logic [RW-1:0]          rem_raw;
   logic [RW-1:0]          rem_fix;
   logic [FRAME_NUM_W-1:0] quot_fix;
   logic                   frame_ok;
   logic [CW-1:0]          stop_w;
   logic [WORD_BITS-1:0]   init_mask;
   logic                   init_last;

   pfba_map #(
      .MAP_WORDS (MAP_WORDS),
      .WORD_BITS (WORD_BITS)
   ) u_map (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .summary   (summary),
      .group_any (group_any)
   );

   assign req_mode_t = mode_type'(req_mode);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // allocate search: group flags, then word flags, then bits of the word
   assign grp_sel     = lowest_set(64'(group_any));
   assign word_sel    = lowest_set(summary[grp_ff*SUM_GROUP +: SUM_GROUP]);
   assign word_full   = {grp_ff, word_sel.idx};
   assign word_pick   = word_full[AW-1:0];
   assign bit_sel     = lowest_set(64'(rd_data));
   assign alloc_frame = FW'(word_ff) * FW'(WORD_BITS) + FW'(bit_sel.idx);

   // free: word index by reciprocal, remainder with one correction step
   assign div_prod = PW'(frame_ff) * PW'(RECIP);
   assign quot_wb  = RW'(quot_ff) * RW'(WORD_BITS);
   assign rem_raw  = RW'(frame_ff) - quot_wb;
   always_comb begin
      if (rem_raw >= RW'(WORD_BITS)) begin
         rem_fix  = rem_raw - RW'(WORD_BITS);
         quot_fix = quot_ff + FRAME_NUM_W'(1);
      end else begin
         rem_fix  = rem_raw;
         quot_fix = quot_ff;
      end
   end
   assign frame_ok = CW'(frame_ff) < CW'(TOTAL);

   // initialize: free bits of the current word between first and clamped end
   assign stop_w    = (CW'(end_ff) > CW'(TOTAL)) ? CW'(TOTAL) : CW'(end_ff);
   assign init_last = (word_ff == AW'(MAP_WORDS - 1));
   always_comb begin
      for (int j = 0; j < WORD_BITS; j++) begin
         init_mask[j] = (base_ff + CW'(j) >= CW'(first_ff)) && (base_ff + CW'(j) < stop_w);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_mode_t)
                  MODE_ALLOC: state_in = ST_GROUP;
                  MODE_FREE:  state_in = ST_FREE_DIV;
                  MODE_INIT:  state_in = ST_INIT;
                  MODE_NOP:   state_in = ST_RESP;
                  default:    state_in = ST_RESP;
               endcase
            end
         end
         ST_GROUP:    state_in = grp_sel.found ? ST_WORD : ST_RESP;
         ST_WORD:     state_in = ST_ALLOC;
         ST_ALLOC:    state_in = out_free ? ST_IDLE : ST_ALLOC;
         ST_FREE_DIV: state_in = ST_FREE_RD;
         ST_FREE_RD:  state_in = frame_ok ? ST_FREE_WB : ST_RESP;
         ST_FREE_WB:  state_in = out_free ? ST_IDLE : ST_FREE_WB;
         ST_INIT:     state_in = (init_last && out_free) ? ST_IDLE : ST_INIT;
         ST_RESP:     state_in = out_free ? ST_IDLE : ST_RESP;
         default:     state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall  = 1'b1;
      rd_en      = 1'b0;
      rd_addr    = word_pick;
      wr_en      = 1'b0;
      wr_addr    = word_ff;
      wr_data    = '0;
      finish     = 1'b0;
      fin_frame  = '0;
      fin_status = STATUS_DONE;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_WORD: begin
            rd_en = 1'b1;
         end
         ST_ALLOC: begin
            wr_en     = out_free;
            wr_data   = rd_data & ~(WORD_BITS'(1) << bit_sel.idx);
            finish    = out_free;
            fin_frame = alloc_frame[FRAME_NUM_W-1:0];
         end
         ST_FREE_RD: begin
            rd_en   = frame_ok;
            rd_addr = quot_fix[AW-1:0];
         end
         ST_FREE_WB: begin
            wr_en   = out_free;
            wr_data = rd_data | (WORD_BITS'(1) << bit_ff);
            finish  = out_free;
         end
         ST_INIT: begin
            wr_en   = !init_last || out_free;
            wr_data = init_mask;
            finish  = init_last && out_free;
         end
         ST_RESP: begin
            finish     = out_free;
            fin_status = pend_status_ff;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // working registers of the current transaction
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            frame_ff       <= req_frame_number;
            word_ff        <= '0;
            base_ff        <= '0;
            pend_status_ff <= STATUS_DONE;
         end
         ST_GROUP: begin
            grp_ff <= grp_sel.idx[GW-1:0];
            if (!grp_sel.found) begin
               pend_status_ff <= STATUS_EMPTY;
            end
         end
         ST_WORD: begin
            word_ff <= word_pick;
         end
         ST_FREE_DIV: begin
            quot_ff <= div_prod[SH +: FRAME_NUM_W];
         end
         ST_FREE_RD: begin
            word_ff <= quot_fix[AW-1:0];
            bit_ff  <= rem_fix[BW-1:0];
         end
         ST_INIT: begin
            if (!init_last) begin
               word_ff <= word_ff + AW'(1);
               base_ff <= base_ff + CW'(WORD_BITS);
            end
         end
         default: begin
            grp_ff <= grp_ff;
         end
      endcase
   end

   // configuration registers, written only while idle
   assign csr_ready = (state_ff == ST_IDLE);
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0;
         end_ff   <= CFG_W'(END_RESET);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_FIRST_FREE: first_ff <= csr_wdata;
            CSR_END_FRAME:  end_ff   <= csr_wdata;
            default:        first_ff <= first_ff;
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_frame_ff  <= fin_frame;
         rsp_status_ff <= fin_status;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_frame = rsp_frame_ff;
   assign rsp_status        = rsp_status_ff;

`ifndef SYNTHESIS
   // a word chosen by the flag search always holds a free frame
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ALLOC |-> rd_data != '0)
      else $error("allocate read an empty map word");

   // an empty report never carries a frame number
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_EMPTY) |-> rsp_granted_frame == '0)
      else $error("empty status with nonzero frame");

   // the map is written only by allocate, free and initialize steps
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_ALLOC || state_ff == ST_FREE_WB || state_ff == ST_INIT))
      else $error("map write outside a write step");

   // a finished transaction leaves a result waiting in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid)
      else $error("finished transaction lost its result");
`endif

endmodule

@@ tb/page_frame_bitmap_allocator_checker.sv @@
module page_frame_bitmap_allocator_checker
   import pfba_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [MODE_W-1:0]      req_mode,
   input  logic [FRAME_NUM_W-1:0] req_frame_number,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [FRAME_NUM_W-1:0] rsp_granted_frame,
   input  logic                   rsp_status,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [CFG_W-1:0]       csr_wdata,
   output int                     mismatch_count,
   output int                     grants_outstanding
);

   localparam int NUM_WORDS    = MAP_WORDS_DEF;
   localparam int NUM_BITS     = WORD_BITS_DEF;
   localparam int TOTAL_FRAMES = NUM_WORDS * NUM_BITS;

   typedef struct packed {
      logic [FRAME_NUM_W-1:0] frame;
      logic                   status;
   } grant_type;

   // local copy of the free map and the two registers
   logic [NUM_BITS-1:0] frame_map [NUM_WORDS];
   logic [CFG_W-1:0]    low_frame;
   logic [CFG_W-1:0]    stop_frame;
   grant_type           pending_grants [$];

   // mark one frame free, frames past the map are dropped
   function automatic void release_frame(int f);
      if (f < TOTAL_FRAMES) begin
         frame_map[f / NUM_BITS][f % NUM_BITS] = 1'b1;
      end
   endfunction

   // apply one request to the local map and return the grant it yields
   function automatic grant_type next_grant(mode_type mode, logic [FRAME_NUM_W-1:0] frame);
      grant_type g;
      int        limit;
      bit        hit;
      g.frame  = '0;
      g.status = STATUS_DONE;
      hit      = 1'b0;
      case (mode)
         MODE_ALLOC: begin
            // lowest set bit of the lowest nonempty word
            for (int w = 0; w < NUM_WORDS && !hit; w++) begin
               if (frame_map[w] != '0) begin
                  for (int b = 0; b < NUM_BITS && !hit; b++) begin
                     if (frame_map[w][b]) begin
                        frame_map[w][b] = 1'b0;
                        g.frame         = FRAME_NUM_W'(w * NUM_BITS + b);
                        hit             = 1'b1;
                     end
                  end
               end
            end
            if (!hit) begin
               g.status = STATUS_EMPTY;
            end
         end
         MODE_FREE: begin
            release_frame(int'(frame));
         end
         MODE_INIT: begin
            // end frame clamps to the map size
            limit = (int'(stop_frame) > TOTAL_FRAMES) ? TOTAL_FRAMES : int'(stop_frame);
            for (int w = 0; w < NUM_WORDS; w++) begin
               frame_map[w] = '0;
            end
            for (int f = int'(low_frame); f < limit; f++) begin
               release_frame(f);
            end
         end
         default: begin
         end
      endcase
      return g;
   endfunction

   // follow register writes, predict on request, compare on response
   always @(posedge clock) begin
      grant_type want;
      if (reset) begin
         for (int w = 0; w < NUM_WORDS; w++) begin
            frame_map[w] = '0;
         end
         low_frame      = '0;
         stop_frame     = CFG_W'(END_RESET);
         pending_grants.delete();
         mismatch_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index_type'(csr_index) == CSR_FIRST_FREE) begin
               low_frame = csr_wdata;
            end else begin
               stop_frame = csr_wdata;
            end
         end
         if (req_valid && !req_stall) begin
            pending_grants.push_back(next_grant(mode_type'(req_mode), req_frame_number));
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_grants.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected transaction, expected none, got frame %0d status %0d",
                        $time, rsp_granted_frame, rsp_status);
            end else begin
               want = pending_grants.pop_front();
               if (rsp_granted_frame !== want.frame) begin
                  mismatch_count++;
                  $display("%0t: granted_frame mismatch, expected %0d, got %0d",
                           $time, want.frame, rsp_granted_frame);
               end
               if (rsp_status !== want.status) begin
                  mismatch_count++;
                  $display("%0t: status mismatch, expected %0d, got %0d",
                           $time, want.status, rsp_status);
               end
            end
         end
      end
      grants_outstanding <= pending_grants.size();
   end

endmodule

@@ tb/page_frame_bitmap_allocator_top_tb.sv @@
module page_frame_bitmap_allocator_top_tb;
   import pfba_pkg::*;

   localparam int TOTAL_FRAMES     = MAP_WORDS_DEF * WORD_BITS_DEF;
   localparam int FIXED_SETTINGS   = 7;
   localparam int SETTING_COUNT    = 12;
   localparam int ITEMS_PER_SETTING = 44;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [MODE_W-1:0]      req_mode;
   logic [FRAME_NUM_W-1:0] req_frame_number;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [FRAME_NUM_W-1:0] rsp_granted_frame;
   logic                   rsp_status;
   logic                   csr_valid;
   logic                   csr_ready;
   logic                   csr_index;
   logic [CFG_W-1:0]       csr_wdata;

   int mismatch_count;
   int grants_outstanding;
   int burst_left = 0;
   int mode_tally [4];
   int settings_applied = 0;
   int stall_hold = 0;
   int stall_style = 0;

   // register settings with the corner cases: clamp, empty range, word edges
   logic [CFG_W-1:0] first_list [FIXED_SETTINGS] = '{0, 16384, 32767, 100, 63, 16380, 0};
   logic [CFG_W-1:0] end_list   [FIXED_SETTINGS] = '{32767, 16384, 0, 110, 129, 32767, 0};

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   page_frame_bitmap_allocator_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_frame_number  (req_frame_number),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_granted_frame (rsp_granted_frame),
      .rsp_status        (rsp_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   page_frame_bitmap_allocator_checker frame_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_frame_number   (req_frame_number),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_granted_frame  (rsp_granted_frame),
      .rsp_status         (rsp_status),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .mismatch_count     (mismatch_count),
      .grants_outstanding (grants_outstanding)
   );

   // response stall: style is picked anew each time a random hold runs out
   always @(negedge clock) begin
      if (stall_hold == 0) begin
         stall_style <= $urandom_range(0, 3);
         stall_hold  <= $urandom_range(20, 300);
      end else begin
         stall_hold <= stall_hold - 1;
      end
      case (stall_style)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
         2: begin
            rsp_stall <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_stall <= ((stall_hold % 5) < 2);
         end
      endcase
   end

   // one request transaction, then either stay in the burst or take a gap
   task automatic send_item(mode_type m, logic [FRAME_NUM_W-1:0] f);
      req_valid        <= 1'b1;
      req_mode         <= m;
      req_frame_number <= f;
      mode_tally[m]++;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid        <= 1'b0;
         req_mode         <= MODE_W'($urandom);
         req_frame_number <= FRAME_NUM_W'($urandom);
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 6);
      end
   endtask

   // hold off requests until every grant has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (grants_outstanding != 0) @(negedge clock);
   endtask

   // write both registers back to back
   task automatic apply_setting(logic [CFG_W-1:0] first, logic [CFG_W-1:0] stop);
      csr_valid <= 1'b1;
      csr_index <= CSR_FIRST_FREE;
      csr_wdata <= first;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_index <= CSR_END_FRAME;
      csr_wdata <= stop;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   // mostly allocate and free inside the usable range, some stray frees
   task automatic send_random(logic [CFG_W-1:0] first, logic [CFG_W-1:0] stop);
      int                     pick;
      int                     lo;
      int                     hi;
      logic [FRAME_NUM_W-1:0] f;
      lo   = int'(first);
      hi   = (int'(stop) > TOTAL_FRAMES) ? TOTAL_FRAMES : int'(stop);
      pick = $urandom_range(0, 99);
      f    = FRAME_NUM_W'($urandom);
      if (pick < 50) begin
         send_item(MODE_ALLOC, f);
      end else if (pick < 80) begin
         if (lo < hi && $urandom_range(0, 2) != 0) begin
            f = FRAME_NUM_W'($urandom_range(lo, hi - 1));
         end
         send_item(MODE_FREE, f);
      end else if (pick < 86) begin
         send_item(MODE_INIT, f);
      end else begin
         send_item(MODE_NOP, f);
      end
   endtask

   initial begin
      logic [CFG_W-1:0] first;
      logic [CFG_W-1:0] stop;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_mode         = MODE_NOP;
      req_frame_number = '0;
      csr_valid        = 1'b0;
      csr_index        = CSR_FIRST_FREE;
      csr_wdata        = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty map after reset, edge frames, double free, full init
      send_item(MODE_ALLOC, 14'h0000);
      send_item(MODE_NOP, 14'h3fff);
      send_item(MODE_FREE, 14'h0000);
      send_item(MODE_FREE, 14'h3fff);
      send_item(MODE_FREE, 14'h3fff);
      send_item(MODE_ALLOC, 14'h3fff);
      send_item(MODE_ALLOC, 14'h0000);
      send_item(MODE_ALLOC, 14'h2aaa);
      send_item(MODE_FREE, 14'h2aaa);
      send_item(MODE_FREE, 14'h1555);
      send_item(MODE_ALLOC, 14'h1555);
      send_item(MODE_INIT, 14'h2aaa);
      send_item(MODE_ALLOC, 14'h1555);
      send_item(MODE_ALLOC, 14'h0000);
      send_item(MODE_FREE, 14'h0000);
      send_item(MODE_ALLOC, 14'h3fff);
      send_item(MODE_NOP, 14'h0000);

      // one phase per register setting, each starting from a fresh map
      for (int s = 0; s < SETTING_COUNT; s++) begin
         if (s < FIXED_SETTINGS) begin
            first = first_list[s];
            stop  = end_list[s];
         end else if (s < SETTING_COUNT - 1) begin
            first = CFG_W'($urandom_range(0, TOTAL_FRAMES));
            stop  = ($urandom_range(0, 1) == 0) ? CFG_W'(first + $urandom_range(0, 150))
                                                : CFG_W'($urandom);
         end else begin
            first = '0;
            stop  = CFG_W'(END_RESET);
         end
         drain();
         apply_setting(first, stop);
         send_item(MODE_INIT, FRAME_NUM_W'($urandom));
         for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
            send_random(first, stop);
            if ($urandom_range(0, 49) == 0) begin
               drain();
            end
         end
      end

      // let the last grants come back, then a margin for stray responses
      drain();
      repeat (MAP_WORDS_DEF + 40) @(negedge clock);
      $display("summary: %0d allocate, %0d free, %0d initialize, %0d no-op requests",
               mode_tally[MODE_ALLOC], mode_tally[MODE_FREE], mode_tally[MODE_INIT],
               mode_tally[MODE_NOP]);
      $display("summary: %0d register settings, clamped and empty ranges included",
               settings_applied);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // run limit
   initial begin
      #10000000;
      $display("tb: failure");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/pfba_pkg.sv
hw/rtl/pfba_map.sv
hw/rtl/page_frame_bitmap_allocator_top.sv
tb/page_frame_bitmap_allocator_checker.sv
tb/page_frame_bitmap_allocator_top_tb.sv
